>>> rtl/mtm_pkg.sv
// ----------------------------------------------------------------------------
// Mutex table manager package
// Shared sizes, codes, entry layout and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package mtm_pkg;

  // Table depth and stored owner width.
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned THREAD_BITS   = 16;

  // Field widths of the request and response.
  localparam int unsigned ActW    = 2;
  localparam int unsigned IdentW  = 31;
  localparam int unsigned CallerW = 16;
  localparam int unsigned StatW   = 2;

  // Entry index and scan counter widths.
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  typedef logic [IdxW-1:0]        idx_t;
  typedef logic [CntW-1:0]        cnt_t;
  typedef logic [IdentW-1:0]      ident_t;
  typedef logic [THREAD_BITS-1:0] owner_t;

  localparam cnt_t   ScanEnd  = cnt_t'(TABLE_ENTRIES);
  localparam ident_t IdentMax = {IdentW{1'b1}};
  localparam ident_t IdentOne = ident_t'(1);

  // Request actions.
  localparam logic [ActW-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ActW-1:0] ACT_DEALLOC = 2'd1;
  localparam logic [ActW-1:0] ACT_LOCK    = 2'd2;
  localparam logic [ActW-1:0] ACT_UNLOCK  = 2'd3;

  // Entry states.
  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_UNLOCKED = 2'd1;
  localparam logic [1:0] ST_LOCKED   = 2'd2;

  // Response status codes.
  localparam logic [StatW-1:0] RES_OK        = 2'd0;
  localparam logic [StatW-1:0] RES_FAIL      = 2'd1;
  localparam logic [StatW-1:0] RES_BUSY      = 2'd2;
  localparam logic [StatW-1:0] RES_FREE_LOCK = 2'd3;

  // One table entry; all zero is the reset value.
  typedef struct packed {
    logic [1:0] state;
    ident_t     ident;
    owner_t     owner;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step;
    logic commit;
  } mtm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } mtm_stat_t;

  // Keep the caller identifier in THREAD_BITS bits.
  function automatic owner_t to_owner(logic [CallerW-1:0] caller);
    owner_t o;
    o = '0;
    for (int i = 0; i < int'(THREAD_BITS); i++) begin
      if (i < int'(CallerW)) begin
        o[i] = caller[i];
      end
    end
    return o;
  endfunction

endpackage

>>> rtl/mtm_req_if.sv
// ----------------------------------------------------------------------------
// Mutex table request channel
// Valid/ready channel that carries one request transaction.
// ----------------------------------------------------------------------------
interface mtm_req_if;
  logic                           valid;
  logic                           ready;
  logic [mtm_pkg::ActW-1:0]       action;
  logic [mtm_pkg::IdentW-1:0]     mutex_ident;
  logic [mtm_pkg::CallerW-1:0]    caller_thread;

  modport source (output valid, output action, output mutex_ident, output caller_thread,
                  input ready);
  modport sink (input valid, input action, input mutex_ident, input caller_thread,
                output ready);
endinterface

>>> rtl/mtm_rsp_if.sv
// ----------------------------------------------------------------------------
// Mutex table response channel
// Valid/ready channel that carries one response transaction.
// ----------------------------------------------------------------------------
interface mtm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mtm_pkg::StatW-1:0]    status;
  logic [mtm_pkg::IdentW-1:0]   new_ident;
  logic                         wake_waiters;

  modport source (output valid, output status, output new_ident, output wake_waiters,
                  input ready);
  modport sink (input valid, input status, input new_ident, input wake_waiters,
                output ready);
endinterface

>>> rtl/mtm_ctrl.sv
// ----------------------------------------------------------------------------
// Mutex table controller
// Sequences accept, table scan and the decide/write step of each request.
// ----------------------------------------------------------------------------
module mtm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  mtm_pkg::mtm_stat_t stat_i,
  output mtm_pkg::mtm_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.hit || stat_i.scan_end) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // Wait here until the response register can take the result.
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/mtm_datapath.sv
// ----------------------------------------------------------------------------
// Mutex table datapath
// Entry memory, scan counter, match logic, decision, counter and response register.
// ----------------------------------------------------------------------------
module mtm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mtm_pkg::mtm_cmd_t             cmd_i,
  output mtm_pkg::mtm_stat_t            stat_o,
  input  logic [mtm_pkg::ActW-1:0]      action_i,
  input  logic [mtm_pkg::IdentW-1:0]    mutex_ident_i,
  input  logic [mtm_pkg::CallerW-1:0]   caller_thread_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [mtm_pkg::StatW-1:0]     status_o,
  output logic [mtm_pkg::IdentW-1:0]    new_ident_o,
  output logic                          wake_waiters_o
);

  // Latched request.
  logic [mtm_pkg::ActW-1:0] action_q;
  mtm_pkg::ident_t          ident_q;
  mtm_pkg::owner_t          caller_q;

  // Scan and read pipeline.
  mtm_pkg::cnt_t   cnt_q;
  logic            rd_pend_q;
  mtm_pkg::idx_t   rd_idx_q;
  mtm_pkg::entry_t rd_data_q;
  logic            rd_vld_q;
  mtm_pkg::entry_t rd_entry;
  logic            rd_en;
  mtm_pkg::idx_t   rd_addr;
  logic            match;

  // Captured hit.
  logic            found_q;
  mtm_pkg::idx_t   hit_idx_q;
  mtm_pkg::entry_t hit_entry_q;

  // Table storage and per-entry valid bits.
  mtm_pkg::entry_t                      mem_q [mtm_pkg::TABLE_ENTRIES];
  logic [mtm_pkg::TABLE_ENTRIES-1:0]    valid_q;

  mtm_pkg::ident_t ident_cnt_q;

  // Decision results.
  logic [mtm_pkg::StatW-1:0] res_status;
  mtm_pkg::ident_t           res_given;
  logic                      res_wake;
  logic                      wr_en;
  mtm_pkg::entry_t           wr_data;

  logic                      out_valid_q;
  logic [mtm_pkg::StatW-1:0] out_status_q;
  mtm_pkg::ident_t           out_ident_q;
  logic                      out_wake_q;

  // Read side: an entry never written reads as free with zero fields.
  assign rd_addr  = cnt_q[mtm_pkg::IdxW-1:0];
  assign rd_en    = cmd_i.step && (cnt_q != mtm_pkg::ScanEnd);
  assign rd_entry = rd_vld_q ? rd_data_q : '0;

  // Allocate looks for a free entry, the others for a nonzero identifier.
  always_comb begin
    if (action_q == mtm_pkg::ACT_ALLOC) begin
      match = (rd_entry.state == mtm_pkg::ST_FREE);
    end else begin
      match = (ident_q != '0) && (rd_entry.ident == ident_q);
    end
  end

  assign stat_o.hit      = rd_pend_q && match;
  assign stat_o.scan_end = !rd_pend_q && (cnt_q == mtm_pkg::ScanEnd);
  assign stat_o.out_free = !out_valid_q || rsp_ready_i;

  // Decide the outcome from the captured entry.
  always_comb begin
    res_status = mtm_pkg::RES_FAIL;
    res_given  = '0;
    res_wake   = 1'b0;
    wr_en      = 1'b0;
    wr_data    = hit_entry_q;
    case (action_q)
      mtm_pkg::ACT_ALLOC: begin
        if (found_q) begin
          wr_en         = 1'b1;
          wr_data.state = mtm_pkg::ST_UNLOCKED;
          wr_data.ident = ident_cnt_q;
          wr_data.owner = '0;
          res_status    = mtm_pkg::RES_OK;
          res_given     = ident_cnt_q;
        end
      end
      mtm_pkg::ACT_DEALLOC: begin
        if (found_q && (hit_entry_q.state != mtm_pkg::ST_LOCKED)) begin
          wr_en      = 1'b1;
          wr_data    = '0;
          res_status = mtm_pkg::RES_OK;
        end
      end
      mtm_pkg::ACT_LOCK: begin
        if (found_q) begin
          if (hit_entry_q.state == mtm_pkg::ST_FREE) begin
            res_status = mtm_pkg::RES_FREE_LOCK;
          end else if (hit_entry_q.state == mtm_pkg::ST_LOCKED) begin
            res_status = mtm_pkg::RES_BUSY;
          end else begin
            wr_en         = 1'b1;
            wr_data.state = mtm_pkg::ST_LOCKED;
            wr_data.owner = caller_q;
            res_status    = mtm_pkg::RES_OK;
          end
        end
      end
      mtm_pkg::ACT_UNLOCK: begin
        if (found_q && (hit_entry_q.state == mtm_pkg::ST_LOCKED) &&
            (hit_entry_q.owner == caller_q)) begin
          wr_en         = 1'b1;
          wr_data.state = mtm_pkg::ST_UNLOCKED;
          wr_data.owner = '0;
          res_status    = mtm_pkg::RES_OK;
          res_wake      = 1'b1;
        end
      end
      default: begin
        res_status = mtm_pkg::RES_FAIL;
      end
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem_q[hit_idx_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_i;
      ident_q  <= mutex_ident_i;
      caller_q <= mtm_pkg::to_owner(caller_thread_i);
    end
    if (rd_en) begin
      rd_idx_q <= rd_addr;
      rd_vld_q <= valid_q[rd_addr];
    end
    if (cmd_i.step && stat_o.hit) begin
      hit_idx_q   <= rd_idx_q;
      hit_entry_q <= rd_entry;
    end
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_ident_q  <= res_given;
      out_wake_q   <= res_wake;
    end
  end

  // Control registers: scan progress, hit flag, valid bits, counter, response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      valid_q     <= '0;
      ident_cnt_q <= mtm_pkg::IdentOne;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        cnt_q     <= '0;
        rd_pend_q <= 1'b0;
        found_q   <= 1'b0;
      end else if (cmd_i.step) begin
        rd_pend_q <= rd_en;
        if (rd_en) begin
          cnt_q <= cnt_q + mtm_pkg::cnt_t'(1);
        end
        if (stat_o.hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit && wr_en) begin
        valid_q[hit_idx_q] <= 1'b1;
      end
      if (cmd_i.commit && found_q && (action_q == mtm_pkg::ACT_ALLOC)) begin
        ident_cnt_q <= (ident_cnt_q == mtm_pkg::IdentMax) ? mtm_pkg::IdentOne
                                                          : ident_cnt_q + mtm_pkg::IdentOne;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign new_ident_o    = out_ident_q;
  assign wake_waiters_o = out_wake_q;

endmodule

>>> rtl/mutex_table_manager_top.sv
// ----------------------------------------------------------------------------
// Mutex table manager
// Table of mutex entries serving allocate, deallocate, lock and unlock requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request transaction (action, mutex_ident, caller_thread);
//   rsp_o returns exactly one response transaction (status, new_ident,
//   wake_waiters) per request, in request order.
//   Each request scans the entry memory one entry per cycle through its single
//   registered read port, stopping at the first match, or after the last entry
//   when none matches. A new request is taken in the cycle after the previous
//   response is loaded; while one request is in work, no new one is accepted.
//   The response sits in an output register; the next request is accepted and
//   scanned while it waits, and only the final write step holds if rsp_o stalls.
//   Reset marks every entry free through per-entry valid bits and sets the
//   identifier counter to one; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module mutex_table_manager_top (
  input logic     clk_i,
  input logic     rst_ni,
  mtm_req_if.sink   req_i,
  mtm_rsp_if.source rsp_o
);

  mtm_pkg::mtm_cmd_t  cmd;
  mtm_pkg::mtm_stat_t stat;
  logic               ready;

  // Controller.
  mtm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  assign req_i.ready = ready;

  // Datapath.
  mtm_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (req_i.action),
    .mutex_ident_i   (req_i.mutex_ident),
    .caller_thread_i (req_i.caller_thread),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .status_o        (rsp_o.status),
    .new_ident_o     (rsp_o.new_ident),
    .wake_waiters_o  (rsp_o.wake_waiters)
  );

endmodule

>>> rtl/mtm_checker.sv
// ----------------------------------------------------------------------------
// Mutex table manager checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module mtm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [mtm_pkg::StatW-1:0]     rsp_status_i,
  input logic [mtm_pkg::IdentW-1:0]    rsp_new_ident_i,
  input logic                          rsp_wake_i
);

  // A stalled response stays valid with the same payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
    $stable(rsp_new_ident_i) && $stable(rsp_wake_i))
    else $error("response changed while stalled");

  // An accepted request keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one still in work");

  // A handed-out identifier only comes with a successful status.
  a_ident_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_new_ident_i != '0) |-> rsp_status_i == mtm_pkg::RES_OK)
    else $error("identifier given on a failed request");

  // Wake only on a successful unlock, which never hands out an identifier.
  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_wake_i |-> (rsp_status_i == mtm_pkg::RES_OK) &&
    (rsp_new_ident_i == '0))
    else $error("wake flag on a response that is not a successful unlock");

endmodule

bind mutex_table_manager_top mtm_checker u_mtm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_new_ident_i (rsp_o.new_ident),
  .rsp_wake_i      (rsp_o.wake_waiters)
);

>>> bench/mutex_table_manager_top_test.sv
// ----------------------------------------------------------------------------
// Mutex table manager testbench
// Drives allocate, deallocate, lock and unlock requests into the table and
// checks every response against a cycle-free model of the table kept here.
// Directed cases come first, then a full-table case, random traffic under
// three idle patterns, and a long response stall that backs up the input.
// ----------------------------------------------------------------------------
module mutex_table_manager_top_test;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned DrainCycles  = mtm_pkg::TABLE_ENTRIES + 16;
  localparam int unsigned RandomItems  = 620;
  localparam int unsigned HoldOffCycles = 300;

  typedef struct packed {
    logic [mtm_pkg::ActW-1:0]    action;
    mtm_pkg::ident_t             mutex_ident;
    logic [mtm_pkg::CallerW-1:0] caller_thread;
  } mutex_req_t;

  typedef struct packed {
    logic [mtm_pkg::StatW-1:0] status;
    mtm_pkg::ident_t           new_ident;
    logic                      wake_waiters;
  } mutex_rsp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mtm_req_if req_if ();
  mtm_rsp_if rsp_if ();

  mutex_table_manager_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Model of the mutex table.
  logic [1:0]      table_state [mtm_pkg::TABLE_ENTRIES];
  mtm_pkg::ident_t table_ident [mtm_pkg::TABLE_ENTRIES];
  mtm_pkg::owner_t table_owner [mtm_pkg::TABLE_ENTRIES];
  mtm_pkg::ident_t next_ident;

  mutex_rsp_t  expected_rsp_q [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rsp_idle_pct = 0;
  int unsigned rsp_hold_request = 0;
  int unsigned rsp_hold_taken = 0;
  int unsigned rsp_hold_left = 0;

  // Clock generation.
  always #5 clk = ~clk;

  // Run time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Response ready: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rsp_hold_request != rsp_hold_taken) begin
      rsp_hold_taken = rsp_hold_request;
      rsp_hold_left  = HoldOffCycles;
    end
    if (rsp_hold_left != 0) begin
      rsp_hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // Every accepted response transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      check_mutex_response();
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] expected,
                                 input logic [31:0] actual);
    mismatch_count++;
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, expected, actual);
  endtask

  task automatic check_mutex_response();
    mutex_rsp_t exp_rsp;
    if (expected_rsp_q.size() == 0) begin
      report_mismatch("response with none outstanding", 32'd0, 32'd1);
    end else begin
      exp_rsp = expected_rsp_q.pop_front();
      if (rsp_if.status !== exp_rsp.status) begin
        report_mismatch("status", 32'(exp_rsp.status), 32'(rsp_if.status));
      end
      if (rsp_if.new_ident !== exp_rsp.new_ident) begin
        report_mismatch("new_ident", 32'(exp_rsp.new_ident), 32'(rsp_if.new_ident));
      end
      if (rsp_if.wake_waiters !== exp_rsp.wake_waiters) begin
        report_mismatch("wake_waiters", 32'(exp_rsp.wake_waiters),
                        32'(rsp_if.wake_waiters));
      end
    end
  endtask

  function automatic void clear_mutex_table();
    int i;
    for (i = 0; i < int'(mtm_pkg::TABLE_ENTRIES); i++) begin
      table_state[i] = mtm_pkg::ST_FREE;
      table_ident[i] = '0;
      table_owner[i] = '0;
    end
    next_ident = mtm_pkg::IdentOne;
  endfunction

  function automatic int count_live_entries();
    int i;
    int live;
    live = 0;
    for (i = 0; i < int'(mtm_pkg::TABLE_ENTRIES); i++) begin
      if (table_state[i] != mtm_pkg::ST_FREE) live++;
    end
    return live;
  endfunction

  // Applies one request to the table model and returns the response it yields.
  function automatic mutex_rsp_t apply_mutex_request(input mutex_req_t r);
    mutex_rsp_t      rsp;
    mtm_pkg::owner_t caller;
    int              hit;
    int              i;
    rsp.status       = mtm_pkg::RES_FAIL;
    rsp.new_ident    = '0;
    rsp.wake_waiters = 1'b0;
    caller = mtm_pkg::owner_t'(r.caller_thread);
    hit = -1;
    if (r.action == mtm_pkg::ACT_ALLOC) begin
      // Claim the lowest free entry.
      for (i = 0; i < int'(mtm_pkg::TABLE_ENTRIES) && hit < 0; i++) begin
        if (table_state[i] == mtm_pkg::ST_FREE) hit = i;
      end
      if (hit >= 0) begin
        table_state[hit] = mtm_pkg::ST_UNLOCKED;
        table_ident[hit] = next_ident;
        table_owner[hit] = '0;
        rsp.new_ident    = next_ident;
        rsp.status       = mtm_pkg::RES_OK;
        next_ident = (next_ident == mtm_pkg::IdentMax) ? mtm_pkg::IdentOne
                                                       : next_ident + mtm_pkg::IdentOne;
      end
    end else begin
      // Identifier zero never matches; otherwise the lowest match wins.
      if (r.mutex_ident != '0) begin
        for (i = 0; i < int'(mtm_pkg::TABLE_ENTRIES) && hit < 0; i++) begin
          if (table_ident[i] == r.mutex_ident) hit = i;
        end
      end
      if (hit >= 0) begin
        case (r.action)
          mtm_pkg::ACT_DEALLOC: begin
            if (table_state[hit] != mtm_pkg::ST_LOCKED) begin
              table_state[hit] = mtm_pkg::ST_FREE;
              table_ident[hit] = '0;
              table_owner[hit] = '0;
              rsp.status = mtm_pkg::RES_OK;
            end
          end
          mtm_pkg::ACT_LOCK: begin
            if (table_state[hit] == mtm_pkg::ST_FREE) begin
              rsp.status = mtm_pkg::RES_FREE_LOCK;
            end else if (table_state[hit] == mtm_pkg::ST_LOCKED) begin
              rsp.status = mtm_pkg::RES_BUSY;
            end else begin
              table_state[hit] = mtm_pkg::ST_LOCKED;
              table_owner[hit] = caller;
              rsp.status = mtm_pkg::RES_OK;
            end
          end
          default: begin
            if (table_state[hit] == mtm_pkg::ST_LOCKED && table_owner[hit] == caller) begin
              table_state[hit] = mtm_pkg::ST_UNLOCKED;
              table_owner[hit] = '0;
              rsp.status = mtm_pkg::RES_OK;
              rsp.wake_waiters = 1'b1;
            end
          end
        endcase
      end
    end
    return rsp;
  endfunction

  // Draws a request that mostly addresses live entries, with some noise.
  function automatic mutex_req_t random_request();
    mutex_req_t r;
    int         live_idx [$];
    int         live;
    int         pick;
    int         i;
    int unsigned roll;
    int unsigned alloc_weight;
    int unsigned dealloc_weight;
    for (i = 0; i < int'(mtm_pkg::TABLE_ENTRIES); i++) begin
      if (table_state[i] != mtm_pkg::ST_FREE) live_idx.push_back(i);
    end
    live = live_idx.size();
    alloc_weight   = (live < 4) ? 60 : (live > 40) ? 10 : 30;
    dealloc_weight = (live > 40) ? 50 : 20;
    pick = -1;

    // Operation.
    roll = $urandom_range(99);
    if (roll < alloc_weight) begin
      r.action = mtm_pkg::ACT_ALLOC;
    end else begin
      roll = $urandom_range(99);
      if (roll < dealloc_weight) r.action = mtm_pkg::ACT_DEALLOC;
      else if (roll < 65) r.action = mtm_pkg::ACT_LOCK;
      else r.action = mtm_pkg::ACT_UNLOCK;
    end

    // Identifier: a live one most of the time.
    roll = $urandom_range(99);
    if (r.action != mtm_pkg::ACT_ALLOC && roll < 75 && live > 0) begin
      pick = live_idx[$urandom_range(live - 1)];
      r.mutex_ident = table_ident[pick];
    end else if (roll < 88) begin
      r.mutex_ident = mtm_pkg::ident_t'($urandom());
    end else if (roll < 94) begin
      r.mutex_ident = '0;
    end else begin
      r.mutex_ident = next_ident - mtm_pkg::ident_t'($urandom_range(8, 1));
    end

    // Caller: the owner for most unlocks, else a small pool or anything.
    roll = $urandom_range(99);
    if (r.action == mtm_pkg::ACT_UNLOCK && pick >= 0 && roll < 70) begin
      r.caller_thread = table_owner[pick];
    end else if (roll < 80) begin
      i = $urandom_range(4);
      r.caller_thread = (i == 4) ? '1 : mtm_pkg::CallerW'(i);
    end else begin
      r.caller_thread = mtm_pkg::CallerW'($urandom());
    end
    return r;
  endfunction

  // Offers one request transaction and records its expected response once taken.
  // Valid stays high afterwards so that back-to-back requests need no gap.
  task automatic send_request(input logic [mtm_pkg::ActW-1:0] action,
                              input mtm_pkg::ident_t ident,
                              input logic [mtm_pkg::CallerW-1:0] caller);
    mutex_req_t r;
    r.action        = action;
    r.mutex_ident   = ident;
    r.caller_thread = caller;
    // The sender idles in a given share of the cycles before each offer.
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.action        <= r.action;
    req_if.mutex_ident   <= r.mutex_ident;
    req_if.caller_thread <= r.caller_thread;
    do @(posedge clk); while (!req_if.ready);
    expected_rsp_q.push_back(apply_mutex_request(r));
  endtask

  // Stops offering requests and waits for all responses plus the block's latency.
  task automatic wait_until_drained();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Zero identifiers, misses, busy, wrong owner and the plain lock cycle.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    rsp_idle_pct  = 0;
    send_request(mtm_pkg::ACT_DEALLOC, '0, '0);
    send_request(mtm_pkg::ACT_LOCK, '0, 16'd1);
    send_request(mtm_pkg::ACT_UNLOCK, '0, '0);
    send_request(mtm_pkg::ACT_LOCK, mtm_pkg::ident_t'(5), 16'd1);
    send_request(mtm_pkg::ACT_ALLOC, mtm_pkg::IdentMax, '1);
    send_request(mtm_pkg::ACT_ALLOC, '0, '0);
    send_request(mtm_pkg::ACT_LOCK, mtm_pkg::ident_t'(1), '1);
    send_request(mtm_pkg::ACT_LOCK, mtm_pkg::ident_t'(1), '1);
    send_request(mtm_pkg::ACT_LOCK, mtm_pkg::ident_t'(1), 16'd7);
    send_request(mtm_pkg::ACT_DEALLOC, mtm_pkg::ident_t'(1), '0);
    send_request(mtm_pkg::ACT_UNLOCK, mtm_pkg::ident_t'(1), 16'd7);
    send_request(mtm_pkg::ACT_UNLOCK, mtm_pkg::ident_t'(1), '1);
    send_request(mtm_pkg::ACT_UNLOCK, mtm_pkg::ident_t'(1), '1);
    send_request(mtm_pkg::ACT_UNLOCK, mtm_pkg::ident_t'(2), '0);
    send_request(mtm_pkg::ACT_LOCK, mtm_pkg::ident_t'(2), '0);
    send_request(mtm_pkg::ACT_UNLOCK, mtm_pkg::ident_t'(2), '0);
    send_request(mtm_pkg::ACT_DEALLOC, mtm_pkg::ident_t'(1), '0);
    send_request(mtm_pkg::ACT_DEALLOC, mtm_pkg::ident_t'(1), '0);
    send_request(mtm_pkg::ACT_LOCK, mtm_pkg::IdentMax, 16'h5A5A);
    send_request(mtm_pkg::ACT_UNLOCK, mtm_pkg::ident_t'(32'h4000_0000), 16'h8000);
    send_request(mtm_pkg::ACT_ALLOC, mtm_pkg::ident_t'(32'h2AAA_AAAA), 16'h5555);
    send_request(mtm_pkg::ACT_DEALLOC, mtm_pkg::ident_t'(2), '0);
    wait_until_drained();
  endtask

  // Fills the table, allocates past full, frees the last and a middle entry, then allocates again.
  task automatic test_table_full();
    while (count_live_entries() < int'(mtm_pkg::TABLE_ENTRIES)) begin
      send_request(mtm_pkg::ACT_ALLOC, '0, '0);
    end
    send_request(mtm_pkg::ACT_ALLOC, '0, '0);
    send_request(mtm_pkg::ACT_ALLOC, mtm_pkg::IdentMax, '1);
    send_request(mtm_pkg::ACT_DEALLOC, table_ident[mtm_pkg::TABLE_ENTRIES-1], '0);
    send_request(mtm_pkg::ACT_DEALLOC, table_ident[10], '0);
    send_request(mtm_pkg::ACT_ALLOC, '0, '0);
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                     input int unsigned rsp_pct);
    mutex_req_t r;
    send_idle_pct = send_pct;
    rsp_idle_pct  = rsp_pct;
    repeat (count) begin
      r = random_request();
      send_request(r.action, r.mutex_ident, r.caller_thread);
    end
    wait_until_drained();
  endtask

  // The response side holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    mutex_req_t r;
    send_idle_pct = 0;
    rsp_idle_pct  = 0;
    rsp_hold_request = rsp_hold_request + 1;
    repeat (12) begin
      r = random_request();
      send_request(r.action, r.mutex_ident, r.caller_thread);
    end
    wait_until_drained();
  endtask

  initial begin
    req_if.valid         <= 1'b0;
    req_if.action        <= mtm_pkg::ACT_ALLOC;
    req_if.mutex_ident   <= '0;
    req_if.caller_thread <= '0;
    clear_mutex_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_table_full();
    test_random_traffic(RandomItems, 22, 45);
    test_output_backpressure();
    test_random_traffic(RandomItems, 45, 22);
    test_random_traffic(RandomItems, 0, 0);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
